/* rtl/jpib_pkg.sv */
package jpib_pkg;

   // input transaction: one stick sample and two button levels
   typedef struct packed {
      logic [7:0] joy_x;
      logic [7:0] joy_y;
      logic       button_c;
      logic       button_z;
   } req_payload_type;

   // result transaction
   typedef struct packed {
      logic [7:0]         radius;
      logic [2:0]         octant;
      logic signed [31:0] sum_x;
      logic signed [31:0] sum_y;
      logic               z_press_event;
      logic               z_release_event;
      logic               mode_advanced;
      logic [2:0]         mode_index;
      logic               channel_advanced;
      logic [3:0]         channel;
   } rsp_payload_type;

   // register file decode, one 32-bit word per register
   localparam int unsigned CsrAddrWidth = 3;

   typedef enum logic {
      CSR_DEAD_ZONE  = 1'b0,
      CSR_MODE_COUNT = 1'b1
   } csr_index_type;

   localparam logic [6:0] DEAD_ZONE_RESET  = 7'd16;
   localparam logic [3:0] MODE_COUNT_RESET = 4'd3;
   localparam logic [3:0] MODE_COUNT_MAX   = 4'd8;
   localparam logic [7:0] AXIS_CENTRE      = 8'd128;
   localparam logic [7:0] RADIUS_MAX       = 8'd128;

endpackage

/* rtl/jpib_if.sv */
interface jpib_req_if;
   logic                      valid;
   logic                      ready;
   jpib_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface jpib_rsp_if;
   logic                      valid;
   logic                      ready;
   jpib_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/joystick_polar_integrator_buttons_core.sv */
// channel   | dir | handshake             | contents
// ----------+-----+-----------------------+--------------------------------------------
// req_chan  | in  | valid/ready           | joy_x, joy_y, button_c, button_z
// rsp_chan  | out | valid/ready           | radius, octant, sums, button events, mode, chan
// apb       | in  | psel/penable, pready  | dead_zone @ 0x0, mode_count @ 0x4
//
// one transaction per clock sustained while rsp_chan.ready stays high; a sample lands in the
// input register, then one pass of combinational logic (two 8x8 squares, 32-bit integrator
// adds, button edge logic) fills the result register, and rsp valid rises as it is loaded
// reset (synchronous, active high) clears integrators, button history, mode, channel
// and both pipeline valids, and loads dead_zone = 16, mode_count = 3
// a stalled rsp holds the result register and the input register; req_chan.ready
// stays high while the input register is empty or moving on
module joystick_polar_integrator_buttons_core (
   input  logic                                  clock,
   input  logic                                  reset,
   jpib_req_if.sink                              req_chan,
   jpib_rsp_if.source                            rsp_chan,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [jpib_pkg::CsrAddrWidth-1:0]     paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   // ---------------------------------------------------------------- config registers
   logic [6:0]              dead_zone_ff, dead_zone_in;
   logic [3:0]              mode_count_ff, mode_count_in;
   jpib_pkg::csr_index_type csr_index;
   logic                    csr_write;

   assign pready    = 1'b1;
   assign csr_index = jpib_pkg::csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      dead_zone_in  = dead_zone_ff;
      mode_count_in = mode_count_ff;
      prdata        = '0;
      unique case (csr_index)
         jpib_pkg::CSR_DEAD_ZONE: begin
            prdata = {25'd0, dead_zone_ff};
            if (csr_write) dead_zone_in = pwdata[6:0];
         end
         jpib_pkg::CSR_MODE_COUNT: begin
            prdata = {28'd0, mode_count_ff};
            if (csr_write) mode_count_in = pwdata[3:0];
         end
         default: prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- pipeline control
   // advance: the result register is free or being emptied this cycle
   logic                      advance;
   logic                      fire;
   logic                      in_valid_ff, in_valid_in;
   jpib_pkg::req_payload_type in_data_ff, in_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   jpib_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign fire           = in_valid_ff && advance;

   assign in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
   assign in_data_in   = (req_chan.ready && req_chan.valid) ? req_chan.payload : in_data_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // ---------------------------------------------------------------- stick geometry
   // centring wraps raw - 128 into a signed byte
   logic signed [7:0]  dx, dy;
   logic signed [8:0]  dx9, dy9, ndx9, ndy9, dz9, ndz9;
   logic signed [15:0] sq_x, sq_y;
   logic [7:0]         radius;
   logic [2:0]         octant;

   assign dx   = signed'(in_data_ff.joy_x - jpib_pkg::AXIS_CENTRE);
   assign dy   = signed'(in_data_ff.joy_y - jpib_pkg::AXIS_CENTRE);
   assign dx9  = 9'(dx);
   assign dy9  = 9'(dy);
   assign ndx9 = -dx9;
   assign ndy9 = -dy9;
   assign sq_x = 16'(dx) * 16'(dx);
   assign sq_y = 16'(dy) * 16'(dy);
   // each square >> 8 is at most 64, so the sum fits a byte
   assign radius = sq_x[15:8] + sq_y[15:8];

   // octants numbered clockwise from straight up
   always_comb begin
      if (!dx[7]) begin
         if (!dy[7]) octant = (dy9 >= dx9) ? 3'd0 : 3'd1;
         else        octant = (ndy9 >= dx9) ? 3'd3 : 3'd2;
      end else begin
         if (!dy[7]) octant = (dy9 >= ndx9) ? 3'd7 : 3'd6;
         else        octant = (ndy9 >= ndx9) ? 3'd4 : 3'd5;
      end
   end

   // ---------------------------------------------------------------- integrators
   logic signed [31:0] integ_x_ff, integ_x_in, integ_y_ff, integ_y_in;
   logic signed [31:0] sum_x, sum_y;
   logic               act_x, act_y;

   assign dz9   = signed'({2'b00, dead_zone_ff});
   assign ndz9  = -dz9;
   assign act_x = (dx9 > dz9) || (dx9 < ndz9);
   assign act_y = (dy9 > dz9) || (dy9 < ndz9);
   // wraps modulo 2^32
   assign sum_x = act_x ? integ_x_ff + 32'(dx) : integ_x_ff;
   assign sum_y = act_y ? integ_y_ff + 32'(dy) : integ_y_ff;

   // ---------------------------------------------------------------- buttons and mode
   logic       prev_c_ff, prev_c_in, prev_z_ff, prev_z_in;
   logic       inhibit_ff, inhibit_in;
   logic [2:0] mode_ff, mode_in;
   logic [3:0] channel_ff, channel_in;
   logic       btn_c, btn_z;
   logic       mode_adv, chan_adv, z_press, z_release;
   logic [3:0] mode_limit, mode_inc;
   logic [2:0] mode_next;
   logic [3:0] channel_next;

   assign btn_c = in_data_ff.button_c;
   assign btn_z = in_data_ff.button_z;

   assign mode_adv  = prev_c_ff && !btn_c && !inhibit_ff;
   assign chan_adv  = prev_c_ff && prev_z_ff && !btn_z;
   assign z_release = !prev_c_ff && prev_z_ff && !btn_z;
   assign z_press   = !prev_c_ff && !prev_z_ff && btn_z;

   // counts above eight behave as eight; a count of zero always lands on mode 0
   assign mode_limit   = (mode_count_ff > jpib_pkg::MODE_COUNT_MAX) ?
                         jpib_pkg::MODE_COUNT_MAX : mode_count_ff;
   assign mode_inc     = {1'b0, mode_ff} + 4'd1;
   assign mode_next    = (mode_inc >= mode_limit) ? 3'd0 : mode_inc[2:0];
   assign channel_next = chan_adv ? channel_ff + 4'd1 : channel_ff;

   always_comb begin
      prev_c_in  = prev_c_ff;
      prev_z_in  = prev_z_ff;
      inhibit_in = inhibit_ff;
      mode_in    = mode_ff;
      channel_in = channel_ff;
      integ_x_in = integ_x_ff;
      integ_y_in = integ_y_ff;
      if (fire) begin
         prev_c_in  = btn_c;
         prev_z_in  = btn_z;
         // inhibit set by a channel step, dropped once C is seen up
         inhibit_in = prev_c_ff ? (inhibit_ff || chan_adv) : 1'b0;
         mode_in    = mode_adv ? mode_next : mode_ff;
         channel_in = channel_next;
         // a mode change clears the integrators after they are reported
         integ_x_in = mode_adv ? '0 : sum_x;
         integ_y_in = mode_adv ? '0 : sum_y;
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (fire) begin
         rsp_data_in.radius           = radius;
         rsp_data_in.octant           = octant;
         rsp_data_in.sum_x            = sum_x;
         rsp_data_in.sum_y            = sum_y;
         rsp_data_in.z_press_event    = z_press;
         rsp_data_in.z_release_event  = z_release;
         rsp_data_in.mode_advanced    = mode_adv;
         rsp_data_in.mode_index       = mode_adv ? mode_next : mode_ff;
         rsp_data_in.channel_advanced = chan_adv;
         rsp_data_in.channel          = channel_next;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff  <= jpib_pkg::DEAD_ZONE_RESET;
         mode_count_ff <= jpib_pkg::MODE_COUNT_RESET;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         integ_x_ff    <= '0;
         integ_y_ff    <= '0;
         prev_c_ff     <= 1'b0;
         prev_z_ff     <= 1'b0;
         inhibit_ff    <= 1'b0;
         mode_ff       <= '0;
         channel_ff    <= '0;
      end else begin
         dead_zone_ff  <= dead_zone_in;
         mode_count_ff <= mode_count_in;
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         integ_x_ff    <= integ_x_in;
         integ_y_ff    <= integ_y_in;
         prev_c_ff     <= prev_c_in;
         prev_z_ff     <= prev_z_in;
         inhibit_ff    <= inhibit_in;
         mode_ff       <= mode_in;
         channel_ff    <= channel_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/jpib_checker.sv */
module jpib_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input jpib_pkg::rsp_payload_type rsp_payload
);

   // a pending result stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_radius_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.radius <= jpib_pkg::RADIUS_MAX)
      else $error("radius out of range");

   // mode steps need C held before, Z events need it released before
   a_mode_vs_z: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.mode_advanced |->
         !rsp_payload.z_press_event && !rsp_payload.z_release_event)
      else $error("mode step together with a Z event");

   a_chan_vs_z: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.channel_advanced |->
         !rsp_payload.z_press_event && !rsp_payload.z_release_event)
      else $error("channel step together with a Z event");

endmodule

bind joystick_polar_integrator_buttons_core jpib_checker u_jpib_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

/* dv/joystick_polar_integrator_buttons_core_tb.sv */
`timescale 1ns / 100ps

module joystick_polar_integrator_buttons_core_tb;

   // tracks the block state and holds the reports still owed by the dut
   class stick_tracker;
      bit [6:0]                  dead_zone_q;
      bit [3:0]                  mode_count_q;
      bit [31:0]                 sum_x_q;
      bit [31:0]                 sum_y_q;
      bit                        c_was;
      bit                        z_was;
      bit                        inhibit_q;
      bit [2:0]                  mode_q;
      bit [3:0]                  channel_q;
      jpib_pkg::rsp_payload_type pending_reports[$];
      int                        mismatches;
      int                        reports_seen;
      int                        mode_steps;
      int                        channel_steps;

      function new();
         dead_zone_q  = jpib_pkg::DEAD_ZONE_RESET;
         mode_count_q = jpib_pkg::MODE_COUNT_RESET;
      endfunction

      function void compare_field(string name, logic signed [63:0] exp_v,
                                  logic signed [63:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
         end
      endfunction

      // one sample in, one report out
      function void take_sample(jpib_pkg::req_payload_type s);
         jpib_pkg::rsp_payload_type r;
         int dx;
         int dy;
         int lim;
         int cnt;
         int nxt;
         dx  = int'(s.joy_x) - int'(jpib_pkg::AXIS_CENTRE);
         dy  = int'(s.joy_y) - int'(jpib_pkg::AXIS_CENTRE);
         lim = dead_zone_q;
         r   = '0;
         r.radius = 8'(((dx * dx) >> 8) + ((dy * dy) >> 8));
         // sector tree, clockwise from up
         if (dx >= 0) begin
            if (dy >= 0) r.octant = (dy >= dx) ? 3'd0 : 3'd1;
            else r.octant = (-dy >= dx) ? 3'd3 : 3'd2;
         end else if (dy >= 0) begin
            r.octant = (dy >= -dx) ? 3'd7 : 3'd6;
         end else begin
            r.octant = (-dy >= -dx) ? 3'd4 : 3'd5;
         end
         if (dx > lim || dx < -lim) sum_x_q += 32'(dx);
         if (dy > lim || dy < -lim) sum_y_q += 32'(dy);
         r.sum_x = sum_x_q;
         r.sum_y = sum_y_q;
         if (c_was) begin
            if (!s.button_c && !inhibit_q) begin
               cnt = (mode_count_q > jpib_pkg::MODE_COUNT_MAX) ?
                     int'(jpib_pkg::MODE_COUNT_MAX) : mode_count_q;
               nxt = mode_q + 1;
               if (nxt >= cnt) nxt = 0;
               mode_q  = 3'(nxt);
               sum_x_q = '0;
               sum_y_q = '0;
               r.mode_advanced = 1'b1;
               mode_steps++;
            end
            if (z_was && !s.button_z) begin
               channel_q++;
               inhibit_q = 1'b1;
               r.channel_advanced = 1'b1;
               channel_steps++;
            end
         end else begin
            inhibit_q = 1'b0;
            if (z_was && !s.button_z) r.z_release_event = 1'b1;
            else if (!z_was && s.button_z) r.z_press_event = 1'b1;
         end
         z_was = s.button_z;
         c_was = s.button_c;
         r.mode_index = mode_q;
         r.channel    = channel_q;
         pending_reports.push_back(r);
      endfunction

      function void match_report(jpib_pkg::rsp_payload_type got);
         jpib_pkg::rsp_payload_type want;
         if (pending_reports.size() == 0) begin
            $error("report with nothing pending: %p", got);
            mismatches++;
            return;
         end
         want = pending_reports.pop_front();
         reports_seen++;
         compare_field("radius", want.radius, got.radius);
         compare_field("octant", want.octant, got.octant);
         compare_field("sum_x", want.sum_x, got.sum_x);
         compare_field("sum_y", want.sum_y, got.sum_y);
         compare_field("z_press_event", want.z_press_event, got.z_press_event);
         compare_field("z_release_event", want.z_release_event, got.z_release_event);
         compare_field("mode_advanced", want.mode_advanced, got.mode_advanced);
         compare_field("mode_index", want.mode_index, got.mode_index);
         compare_field("channel_advanced", want.channel_advanced, got.channel_advanced);
         compare_field("channel", want.channel, got.channel);
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 300000;
   localparam int ITEMS_PER_PHASE = 120;
   localparam int PHASES = 7;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [jpib_pkg::CsrAddrWidth-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   jpib_req_if req_if ();
   jpib_rsp_if rsp_if ();

   stick_tracker tracker = new();

   int  cycle_count;
   int  samples_sent;
   int  settings_seen;
   bit  no_idle;      // when set, neither side inserts gaps
   bit  c_lvl;
   bit  z_lvl;

   byte unsigned axis_extremes[7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};

   joystick_polar_integrator_buttons_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("joystick_polar_integrator_buttons_core_tb: FAIL");
         $finish;
      end
   end

   function automatic jpib_pkg::req_payload_type mk(int x, int y, bit c, bit z);
      jpib_pkg::req_payload_type p;
      p.joy_x    = 8'(x);
      p.joy_y    = 8'(y);
      p.button_c = c;
      p.button_z = z;
      return p;
   endfunction

   // offer one sample, entered and left at a falling edge
   task automatic offer_sample(jpib_pkg::req_payload_type p);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= p;
      do @(posedge clock); while (!req_if.ready);
      // transaction accepted at this edge
      tracker.take_sample(p);
      samples_sent++;
      @(negedge clock);
   endtask

   // one apb setup + access pair, entered and left at a falling edge
   task automatic csr_cycle(bit wr, jpib_pkg::csr_index_type idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // write a register, read it back, and mirror it in the tracker
   task automatic set_register(jpib_pkg::csr_index_type idx, int value);
      logic [31:0] rd;
      csr_cycle(1'b1, idx, 32'(value), rd);
      csr_cycle(1'b0, idx, '0, rd);
      if (idx == jpib_pkg::CSR_DEAD_ZONE) begin
         tracker.dead_zone_q = 7'(value);
         tracker.compare_field("dead_zone readback", tracker.dead_zone_q, rd);
      end else begin
         tracker.mode_count_q = 4'(value);
         tracker.compare_field("mode_count readback", tracker.mode_count_q, rd);
      end
   endtask

   // stop offering, let every owed report arrive, then let the pipe settle
   task automatic wait_drained();
      int n;
      n = 0;
      req_if.valid <= 1'b0;
      while (tracker.pending_reports.size() != 0 && n < 5000) begin
         @(posedge clock);
         n++;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // result side: random stalls, check on every accepted transaction
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         tracker.match_report(rsp_if.payload);
         @(negedge clock);
      end
   end

   initial begin
      logic [31:0] rd;
      int dz_plan[PHASES];
      int mc_plan[PHASES];
      int x;
      int y;
      int d;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      reset   = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values of both registers
      csr_cycle(1'b0, jpib_pkg::CSR_DEAD_ZONE, '0, rd);
      tracker.compare_field("dead_zone after reset", jpib_pkg::DEAD_ZONE_RESET, rd);
      csr_cycle(1'b0, jpib_pkg::CSR_MODE_COUNT, '0, rd);
      tracker.compare_field("mode_count after reset", jpib_pkg::MODE_COUNT_RESET, rd);
      settings_seen = 1;

      // directed: axis extremes, every sector, dead zone edge, button gestures
      offer_sample(mk(128, 128, 0, 0));   // centre
      offer_sample(mk(255, 128, 0, 0));   // full right
      offer_sample(mk(0, 128, 0, 0));     // full left
      offer_sample(mk(128, 255, 0, 0));
      offer_sample(mk(128, 0, 0, 0));
      offer_sample(mk(0, 0, 0, 1));       // z press
      offer_sample(mk(255, 255, 0, 0));   // z release
      offer_sample(mk(255, 0, 0, 0));
      offer_sample(mk(0, 255, 1, 0));     // c down
      offer_sample(mk(200, 56, 0, 0));    // c up: mode steps, sums cleared
      offer_sample(mk(56, 56, 1, 0));
      offer_sample(mk(60, 200, 1, 1));    // z down with c held, no event
      offer_sample(mk(200, 100, 1, 0));   // z up with c held: channel steps
      offer_sample(mk(100, 60, 0, 0));    // c up while inhibited
      offer_sample(mk(60, 100, 1, 0));
      offer_sample(mk(144, 112, 1, 1));   // just inside the dead zone
      offer_sample(mk(145, 111, 0, 0));   // both released together
      offer_sample(mk(112, 144, 0, 0));
      offer_sample(mk(111, 145, 1, 0));
      offer_sample(mk(128, 128, 0, 0));   // mode wraps back to zero
      offer_sample(mk(1, 254, 0, 1));
      offer_sample(mk(254, 1, 0, 0));
      offer_sample(mk(127, 129, 0, 0));
      offer_sample(mk(129, 127, 0, 0));
      wait_drained();

      // register settings per phase, extremes first, then random
      dz_plan = '{0, 127, 40, 5, 64, 16, 0};
      mc_plan = '{1, 8, 2, 0, 15, 3, 0};
      dz_plan[PHASES-1] = $urandom_range(0, 127);
      mc_plan[PHASES-1] = $urandom_range(0, 15);
      c_lvl = 1'b0;
      z_lvl = 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         set_register(jpib_pkg::CSR_DEAD_ZONE, dz_plan[ph]);
         set_register(jpib_pkg::CSR_MODE_COUNT, mc_plan[ph]);
         settings_seen++;
         no_idle = (ph % 3 == 2);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // occasional stretch with no gaps on either side
            if (i % 40 == 39) no_idle = ($urandom_range(0, 3) == 0);
            // button gestures: c held long, z toggling, sometimes a joint release
            if (c_lvl && z_lvl && $urandom_range(0, 15) == 0) begin
               c_lvl = 1'b0;
               z_lvl = 1'b0;
            end else begin
               if ($urandom_range(0, 5) == 0) c_lvl = ~c_lvl;
               if ($urandom_range(0, 2) == 0) z_lvl = ~z_lvl;
            end
            case ($urandom_range(0, 3))
               0: begin
                  // around the centre, straddling the dead zone
                  x = 108 + $urandom_range(0, 40);
                  y = 108 + $urandom_range(0, 40);
               end
               1: begin
                  x = axis_extremes[$urandom_range(0, 6)];
                  y = axis_extremes[$urandom_range(0, 6)];
               end
               2: begin
                  x = $urandom_range(0, 255);
                  y = $urandom_range(0, 255);
               end
               default: begin
                  // diagonals hit the sector boundaries
                  d = $urandom_range(0, 127);
                  x = $urandom_range(0, 1) ? 128 + d : 128 - d;
                  y = $urandom_range(0, 1) ? 128 + d : 128 - d;
               end
            endcase
            offer_sample(mk(x, y, c_lvl, z_lvl));
         end
         wait_drained();
      end

      if (tracker.pending_reports.size() != 0) begin
         $error("%0d reports never arrived", tracker.pending_reports.size());
         tracker.mismatches++;
      end

      $display("run covered %0d samples under %0d register settings, %0d reports checked",
               samples_sent, settings_seen, tracker.reports_seen);
      $display("mode advanced %0d times, channel advanced %0d times",
               tracker.mode_steps, tracker.channel_steps);
      if (tracker.mismatches == 0) begin
         $display("joystick_polar_integrator_buttons_core_tb: PASS");
      end else begin
         $display("joystick_polar_integrator_buttons_core_tb: FAIL");
      end
      $finish;
   end

endmodule

/* joystick_polar_integrator_buttons_core.f */
rtl/jpib_pkg.sv
rtl/jpib_if.sv
rtl/joystick_polar_integrator_buttons_core.sv
rtl/jpib_checker.sv
dv/joystick_polar_integrator_buttons_core_tb.sv
